>>> src/hybrid_branch_predictor_macros.svh
// Assertion macros shared by the branch predictor RTL.
`ifndef HYBRID_BRANCH_PREDICTOR_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define HBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hbp_pkg.sv
// Types and constants of the hybrid branch predictor.
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 32;
  localparam int HLEN_W   = 4;
  localparam int CTR_W    = 3;
  localparam int CHS_W    = 2;

  localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd8;

  localparam logic [CTR_W-1:0] CTR_MAX   = 3'd7;
  localparam logic [CTR_W-1:0] CTR_TAKEN = 3'd4;
  localparam logic [CTR_W-1:0] CTR_INIT  = 3'd4;

  localparam logic [CHS_W-1:0] CHS_MAX  = 2'd3;
  localparam logic [CHS_W-1:0] CHS_SEL  = 2'd2;
  localparam logic [CHS_W-1:0] CHS_INIT = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } in_item_t;

  typedef struct packed {
    logic             predicted_taken;
    logic             mispredicted;
    logic             used_gshare;
    logic [CNT_W-1:0] mispredict_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/hbp_ram.sv
// Single-port-write, single-port-read table RAM with read-during-write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module hbp_ram #(
  parameter int AW = 10,
  parameter int DW = 3
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;
  logic          fwd_hit_r;
  logic [DW-1:0] fwd_data_r;

  // A read in the same cycle as a write to the same entry sees the old
  // value in the array, so the new value is captured alongside it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rdata_r;

endmodule

`default_nettype wire

>>> src/hybrid_branch_predictor.sv
// An accepted item is registered in stage 1, its result in out_data once that is free.
// Throughput: one item per cycle while the output does not stall, set by the
// read-modify-write of each table RAM with a one-entry forward from the write of
// the item just ahead. Reset (synchronous, rst_n low) clears history and miss count
// and sets history_length to 8; a clearing pass then fills the tables with their
// initial values, with in_ready low during it; cfg writes are taken as ever.
`timescale 1ns / 1ps
`default_nettype none

module hybrid_branch_predictor #(
  parameter int CHOOSER_INDEX_BITS = 8,
  parameter int GSHARE_INDEX_BITS  = 10,
  parameter int BIMODAL_INDEX_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hbp_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output hbp_pkg::out_item_t              out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic [hbp_pkg::HLEN_W-1:0] cfg_wr_data
);

`include "hybrid_branch_predictor_macros.svh"

  localparam int CB = CHOOSER_INDEX_BITS;
  localparam int GB = GSHARE_INDEX_BITS;
  localparam int BB = BIMODAL_INDEX_BITS;
  localparam int MAXB_CG = (CB > GB) ? CB : GB;
  localparam int MAXB = (MAXB_CG > BB) ? MAXB_CG : BB;
  localparam int NW = $clog2(GB + 1);

  // Configuration and global state.
  logic [hbp_pkg::HLEN_W-1:0] hlen_r;
  logic [GB-1:0]              hist_r, hist_nxt;
  logic [hbp_pkg::CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;

  // Clearing pass.
  logic            clr_busy_r;
  logic [MAXB-1:0] clr_cnt_r;

  // Stage 1: item whose table reads are in flight.
  logic          s1_valid_r;
  logic          s1_taken_r;
  logic [CB-1:0] ci_r;
  logic [GB-1:0] gi_r;
  logic [BB-1:0] bi_r;

  logic                 out_valid_r;
  hbp_pkg::out_item_t   out_data_r;

  logic                 in_acc, s1_go;
  logic [NW-1:0]        n_eff;
  logic [GB-1:0]        hmask, hist_m;
  logic [CB-1:0]        ci;
  logic [GB-1:0]        gi;
  logic [BB-1:0]        bi;

  logic [hbp_pkg::CHS_W-1:0] c_rd, c_new;
  logic [hbp_pkg::CTR_W-1:0] g_rd, b_rd, sel_ctr, ctr_new;
  logic                      pg, pb, use_g, pred, miss;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_go);
  assign in_acc   = in_valid && in_ready;

  // Effective history length: zero reads as one, large values saturate.
  always_comb begin
    if (hlen_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(hlen_r) > GB) begin
      n_eff = NW'(GB);
    end else begin
      n_eff = NW'(hlen_r);
    end
  end

  always_comb begin
    for (int i = 0; i < GB; i++) begin
      hmask[i] = (i < int'(n_eff));
    end
    hist_m = hist_r & hmask;
    for (int i = 0; i < GB; i++) begin
      if (i + 1 == int'(n_eff)) begin
        hist_nxt[i] = in_data.taken;
      end else if (i + 1 < GB) begin
        hist_nxt[i] = hist_m[(i + 1) % GB];
      end else begin
        hist_nxt[i] = 1'b0;
      end
    end
  end

  assign ci = in_data.branch_address[2 +: CB];
  assign bi = in_data.branch_address[2 +: BB];
  assign gi = in_data.branch_address[2 +: GB] ^ hist_m;

  // Decision and training for the item in stage 1.
  always_comb begin
    pg      = (g_rd >= hbp_pkg::CTR_TAKEN);
    pb      = (b_rd >= hbp_pkg::CTR_TAKEN);
    use_g   = (c_rd >= hbp_pkg::CHS_SEL);
    pred    = use_g ? pg : pb;
    miss    = (pred != s1_taken_r);
    sel_ctr = use_g ? g_rd : b_rd;

    if (s1_taken_r) begin
      ctr_new = (sel_ctr < hbp_pkg::CTR_MAX) ? sel_ctr + 3'd1 : hbp_pkg::CTR_MAX;
    end else begin
      ctr_new = (sel_ctr > '0) ? sel_ctr - 3'd1 : '0;
    end

    c_new = c_rd;
    if (pg == s1_taken_r && pb != s1_taken_r) begin
      if (c_rd < hbp_pkg::CHS_MAX) begin
        c_new = c_rd + 2'd1;
      end
    end else if (pg != s1_taken_r && pb == s1_taken_r) begin
      if (c_rd > '0) begin
        c_new = c_rd - 2'd1;
      end
    end

    miss_cnt_nxt = miss_cnt_r;
    if (miss && miss_cnt_r != '1) begin
      miss_cnt_nxt = miss_cnt_r + 32'd1;
    end
  end

  hbp_ram #(.AW(CB), .DW(hbp_pkg::CHS_W)) u_chooser (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (ci),
    .wr_en   (clr_busy_r || s1_go),
    .wr_addr (clr_busy_r ? clr_cnt_r[CB-1:0] : ci_r),
    .wr_data (clr_busy_r ? hbp_pkg::CHS_INIT : c_new),
    .rd_data (c_rd)
  );

  hbp_ram #(.AW(GB), .DW(hbp_pkg::CTR_W)) u_gshare (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (gi),
    .wr_en   (clr_busy_r || (s1_go && use_g)),
    .wr_addr (clr_busy_r ? clr_cnt_r[GB-1:0] : gi_r),
    .wr_data (clr_busy_r ? hbp_pkg::CTR_INIT : ctr_new),
    .rd_data (g_rd)
  );

  hbp_ram #(.AW(BB), .DW(hbp_pkg::CTR_W)) u_bimodal (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (bi),
    .wr_en   (clr_busy_r || (s1_go && !use_g)),
    .wr_addr (clr_busy_r ? clr_cnt_r[BB-1:0] : bi_r),
    .wr_data (clr_busy_r ? hbp_pkg::CTR_INIT : ctr_new),
    .rd_data (b_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlen_r      <= hbp_pkg::HLEN_RESET;
      hist_r      <= '0;
      miss_cnt_r  <= '0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hlen_r <= cfg_wr_data;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc) begin
        hist_r <= hist_nxt;
      end
      if (s1_go) begin
        miss_cnt_r <= miss_cnt_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_taken_r <= in_data.taken;
      ci_r       <= ci;
      gi_r       <= gi;
      bi_r       <= bi;
    end
    if (s1_go) begin
      out_data_r.predicted_taken  <= pred;
      out_data_r.mispredicted     <= miss;
      out_data_r.used_gshare      <= use_g;
      out_data_r.mispredict_count <= miss_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HBP_ASSERT_NOW(a_clear_empty, clr_busy_r, !s1_valid_r && !out_valid_r, "item in flight during table clearing")
  `HBP_ASSERT_NEXT(a_miss_inc, s1_go && miss && miss_cnt_r != '1, miss_cnt_r == $past(miss_cnt_r) + 32'd1, "miss count did not advance")
  `HBP_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ready, s1_valid_r && $stable(gi_r) && $stable(ci_r), "stage 1 item lost during output stall")
  `HBP_ASSERT_NEXT(a_out_from_s1, s1_go, out_valid_r && out_data_r.used_gshare == $past(use_g), "result not taken from stage 1")

endmodule

`default_nettype wire
